@@ hdl/group_epoch_lease_table_unit_assert.svh @@
// Assertion macros for the group epoch lease table unit.
`ifndef GROUP_EPOCH_LEASE_TABLE_UNIT_ASSERT_SVH
`define GROUP_EPOCH_LEASE_TABLE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GELT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GELT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hdl/gelt_pkg.sv @@
// Types and codes shared by the group epoch lease table unit.
package gelt_pkg;

   localparam int GROUP_INDEX_W = 8;
   localparam int CSR_INDEX_W   = 8;

   // Request actions
   localparam logic [1:0] ACT_CREATE_INIT     = 2'd0;
   localparam logic [1:0] ACT_CREATE_COMPLETE = 2'd1;
   localparam logic [1:0] ACT_COMMIT_INIT     = 2'd2;
   localparam logic [1:0] ACT_COMMIT_COMPLETE = 2'd3;

   // Response status codes
   localparam logic [2:0] RSP_OK        = 3'd0;
   localparam logic [2:0] RSP_CREATED   = 3'd1;
   localparam logic [2:0] RSP_CONFLICT  = 3'd2;
   localparam logic [2:0] RSP_BAD_TXN   = 3'd3;
   localparam logic [2:0] RSP_UNKNOWN   = 3'd4;
   localparam logic [2:0] RSP_BAD_EPOCH = 3'd5;

   // Group life-cycle codes
   localparam logic [1:0] GS_EMPTY    = 2'd0;
   localparam logic [1:0] GS_CREATING = 2'd1;
   localparam logic [1:0] GS_CREATED  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CREATE_LEASE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMIT_LEASE = 8'd1;

   localparam logic [31:0] LEASE_TICKS_RESET = 32'd1000;

   typedef struct packed {
      logic [1:0]               action;
      logic [GROUP_INDEX_W-1:0] group_index;
      logic [31:0]              epoch_asked;
      logic [63:0]              txn_presented;
      logic [63:0]              fresh_txn;
      logic [31:0]              time_now;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] granted_txn;
      logic [31:0] lease_expiry;
      logic [31:0] current_epoch;
   } rsp_type;

   // One group's entry in the table memory
   typedef struct packed {
      logic [1:0]  group_status;
      logic        commit_pending;
      logic [63:0] held_txn;
      logic [31:0] held_expiry;
      logic [31:0] group_epoch;
   } entry_type;

endpackage

@@ hdl/group_epoch_lease_table_unit.sv @@
// Group epoch lease table: top level with the group memory and its update logic.

// Directly indexed table of GROUPS groups, each holding its life-cycle state, a
// commit-pending flag, the id and expiry of the lease held, and its epoch, all in
// one single-port-per-side synchronous memory. Each request yields exactly one
// response. A request first reads its group entry from memory; once the response
// side is free the entry is evaluated, written back if it changes, and the
// response register is loaded. A new request is taken only after the last one
// has loaded its response. The response register lets the next request be taken
// while a response still waits. After reset the block sweeps the memory to clear
// every group, one entry a cycle; no request is taken during that sweep, but
// register writes are. Register writes should be made while idle.
`include "group_epoch_lease_table_unit_assert.svh"

module group_epoch_lease_table_unit #(
   parameter int GROUPS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gelt_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gelt_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gelt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_data
);

   localparam int AW = $clog2(GROUPS);
   localparam int XW = AW + gelt_pkg::GROUP_INDEX_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(GROUPS - 1);
   localparam logic [XW-1:0] GROUPS_X  = XW'(GROUPS);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [31:0]         create_ticks_ff, commit_ticks_ff;
   gelt_pkg::req_type   req_hold_ff;
   logic [AW-1:0]       addr_ff;
   logic                known_ff;
   gelt_pkg::entry_type rd_entry_ff;
   gelt_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   gelt_pkg::entry_type entry_mem [GROUPS];

   logic                req_beat, out_free, finish;
   logic [XW-1:0]       req_index_x;
   logic [AW-1:0]       req_addr;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   gelt_pkg::entry_type mem_wdata;

   // Lookup evaluation
   gelt_pkg::entry_type new_entry;
   gelt_pkg::rsp_type   eval_rsp;
   logic                eval_write;
   logic                created, creating, now_lt_exp, exp_lt_now, txn_match, epoch_match;
   logic [31:0]         lease_ticks, sat_expiry;
   logic [32:0]         expiry_sum;

   // Handshakes
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_beat    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign finish      = (state_ff == ST_LOOKUP) && out_free;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Group index to memory address and range check
   assign req_index_x = {{AW{1'b0}}, req_payload.group_index};
   assign req_addr    = req_index_x[AW-1:0];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         create_ticks_ff <= gelt_pkg::LEASE_TICKS_RESET;
         commit_ticks_ff <= gelt_pkg::LEASE_TICKS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            gelt_pkg::CSR_CREATE_LEASE: create_ticks_ff <= csr_data;
            gelt_pkg::CSR_COMMIT_LEASE: commit_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (req_beat) begin
         req_hold_ff <= req_payload;
         addr_ff     <= req_addr;
         known_ff    <= (req_index_x < GROUPS_X);
      end
   end

   // Group memory: registered read, single write port
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rd_entry_ff <= entry_mem[req_addr];
      end
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Evaluate the request against the group entry
   always_comb begin
      created     = (rd_entry_ff.group_status == gelt_pkg::GS_CREATED);
      creating    = (rd_entry_ff.group_status == gelt_pkg::GS_CREATING);
      now_lt_exp  = req_hold_ff.time_now < rd_entry_ff.held_expiry;
      exp_lt_now  = rd_entry_ff.held_expiry < req_hold_ff.time_now;
      txn_match   = (rd_entry_ff.held_txn == req_hold_ff.txn_presented);
      epoch_match = (rd_entry_ff.group_epoch == req_hold_ff.epoch_asked);
      lease_ticks = (req_hold_ff.action == gelt_pkg::ACT_COMMIT_INIT) ?
                    commit_ticks_ff : create_ticks_ff;
      expiry_sum  = {1'b0, req_hold_ff.time_now} + {1'b0, lease_ticks};
      sat_expiry  = expiry_sum[32] ? 32'hFFFF_FFFF : expiry_sum[31:0];

      new_entry   = rd_entry_ff;
      eval_write  = 1'b0;
      eval_rsp    = '0;
      eval_rsp.status = gelt_pkg::RSP_OK;

      if (!known_ff) begin
         eval_rsp.status = gelt_pkg::RSP_UNKNOWN;
      end else begin
         case (req_hold_ff.action)
            gelt_pkg::ACT_CREATE_INIT: begin
               if (created) begin
                  eval_rsp.status = gelt_pkg::RSP_CREATED;
               end else if (creating && now_lt_exp) begin
                  eval_rsp.status       = gelt_pkg::RSP_CONFLICT;
                  eval_rsp.lease_expiry = rd_entry_ff.held_expiry;
               end else begin
                  new_entry.group_status = gelt_pkg::GS_CREATING;
                  new_entry.held_txn     = req_hold_ff.fresh_txn;
                  new_entry.held_expiry  = sat_expiry;
                  eval_rsp.granted_txn   = req_hold_ff.fresh_txn;
                  eval_write             = 1'b1;
               end
            end
            gelt_pkg::ACT_CREATE_COMPLETE: begin
               if (created) begin
                  eval_rsp.status = gelt_pkg::RSP_CREATED;
               end else if (!creating || !txn_match || exp_lt_now) begin
                  eval_rsp.status = gelt_pkg::RSP_BAD_TXN;
               end else begin
                  new_entry.group_status   = gelt_pkg::GS_CREATED;
                  new_entry.group_epoch    = '0;
                  new_entry.commit_pending = 1'b0;
                  eval_write               = 1'b1;
               end
            end
            gelt_pkg::ACT_COMMIT_INIT: begin
               if (!created) begin
                  eval_rsp.status = gelt_pkg::RSP_UNKNOWN;
               end else if (!epoch_match) begin
                  eval_rsp.status        = gelt_pkg::RSP_BAD_EPOCH;
                  eval_rsp.current_epoch = rd_entry_ff.group_epoch;
               end else if (rd_entry_ff.commit_pending && now_lt_exp) begin
                  eval_rsp.status       = gelt_pkg::RSP_CONFLICT;
                  eval_rsp.lease_expiry = rd_entry_ff.held_expiry;
               end else begin
                  new_entry.commit_pending = 1'b1;
                  new_entry.held_txn       = req_hold_ff.fresh_txn;
                  new_entry.held_expiry    = sat_expiry;
                  eval_rsp.granted_txn     = req_hold_ff.fresh_txn;
                  eval_write               = 1'b1;
               end
            end
            gelt_pkg::ACT_COMMIT_COMPLETE: begin
               if (!created) begin
                  eval_rsp.status = gelt_pkg::RSP_UNKNOWN;
               end else if (!epoch_match) begin
                  eval_rsp.status        = gelt_pkg::RSP_BAD_EPOCH;
                  eval_rsp.current_epoch = rd_entry_ff.group_epoch;
               end else if (!rd_entry_ff.commit_pending || !txn_match || exp_lt_now) begin
                  eval_rsp.status = gelt_pkg::RSP_BAD_TXN;
               end else begin
                  new_entry.group_epoch    = rd_entry_ff.group_epoch + 32'd1;
                  new_entry.commit_pending = 1'b0;
                  eval_write               = 1'b1;
               end
            end
            default: begin
               eval_rsp.status = gelt_pkg::RSP_UNKNOWN;
            end
         endcase
      end
   end

   // Memory write port: clearing sweep or write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = new_entry;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (finish && eval_write) begin
         mem_we = 1'b1;
      end
   end

   // Sequencer and response register
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               rsp_in       = eval_rsp;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Checks
   `GELT_ASSERT_NOW(a_no_req_in_clear, state_ff == ST_CLEAR, !req_ready)
   `GELT_ASSERT_NEXT(a_beat_starts_lookup, req_beat, state_ff == ST_LOOKUP)
   `GELT_ASSERT_NOW(a_no_write_idle, state_ff == ST_IDLE, !mem_we)
   `GELT_ASSERT_NEXT(a_lookup_gives_rsp, finish, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

@@ verif/group_epoch_lease_table_unit_tb.sv @@
// Self-checking testbench for the group epoch lease table unit.
`timescale 1ns / 100ps

module group_epoch_lease_table_unit_tb;

   localparam int GROUPS      = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 120;
   localparam int DRAIN_WAIT  = 8;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 290;
   localparam int MAX_REPORTS = 10;
   localparam int CSR_W       = gelt_pkg::CSR_INDEX_W;
   localparam int IDX_W       = gelt_pkg::GROUP_INDEX_W;

   // Short names for the codes used in the directed table
   localparam logic [1:0] CR_INIT     = gelt_pkg::ACT_CREATE_INIT;
   localparam logic [1:0] CR_DONE     = gelt_pkg::ACT_CREATE_COMPLETE;
   localparam logic [1:0] CM_INIT     = gelt_pkg::ACT_COMMIT_INIT;
   localparam logic [1:0] CM_DONE     = gelt_pkg::ACT_COMMIT_COMPLETE;
   localparam logic [2:0] S_OK        = gelt_pkg::RSP_OK;
   localparam logic [2:0] S_CREATED   = gelt_pkg::RSP_CREATED;
   localparam logic [2:0] S_CONFLICT  = gelt_pkg::RSP_CONFLICT;
   localparam logic [2:0] S_BAD_TXN   = gelt_pkg::RSP_BAD_TXN;
   localparam logic [2:0] S_UNKNOWN   = gelt_pkg::RSP_UNKNOWN;
   localparam logic [2:0] S_BAD_EPOCH = gelt_pkg::RSP_BAD_EPOCH;

   localparam logic [63:0] TXN_A    = 64'hA5A5_0000_1111_2222;
   localparam logic [63:0] TXN_B    = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] TXN_C    = 64'hFEDC_BA98_7654_3210;
   localparam logic [63:0] TXN_ONES = {64{1'b1}};
   localparam logic [31:0] T_MAX    = 32'hFFFF_FFFF;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   gelt_pkg::req_type      req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   gelt_pkg::rsp_type      rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_W-1:0]       csr_index;
   logic [31:0]            csr_data;

   // Typed-in expectation that travels with a directed request beat
   logic                   beat_typed;
   gelt_pkg::rsp_type      beat_typed_rsp;

   group_epoch_lease_table_unit #(.GROUPS(GROUPS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Shadow of the group table and the lease lengths
   logic [1:0]  grp_status  [GROUPS];
   logic        grp_pending [GROUPS];
   logic [63:0] grp_txn     [GROUPS];
   logic [31:0] grp_expiry  [GROUPS];
   logic [31:0] grp_epoch   [GROUPS];
   logic [31:0] create_ticks;
   logic [31:0] commit_ticks;

   gelt_pkg::rsp_type awaited_rsp_q [$];
   int unsigned fault_count;
   int unsigned report_count;
   int unsigned cycle_count;
   int unsigned req_beats;
   int unsigned rsp_beats;
   int unsigned csr_beats;
   int unsigned status_seen [8];
   bit          calm;
   bit          hold_rsp;
   logic [31:0] tick_base;
   int unsigned hot_base;

   typedef struct {
      gelt_pkg::req_type req;
      bit                typed;
      gelt_pkg::rsp_type rsp;
   } dir_row_type;

   dir_row_type dir_rows [$];

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Lease end, saturating at the top of the time range
   function automatic logic [31:0] lease_end(logic [31:0] now, logic [31:0] len);
      logic [32:0] sum;
      sum = {1'b0, now} + {1'b0, len};
      return sum[32] ? T_MAX : sum[31:0];
   endfunction

   // Predict the response to one request and update the shadow table
   function automatic gelt_pkg::rsp_type lease_table_step(gelt_pkg::req_type r);
      gelt_pkg::rsp_type o;
      int unsigned       g;
      logic              created;
      logic              creating;
      o        = '0;
      o.status = gelt_pkg::RSP_OK;
      g        = 32'(r.group_index);
      created  = (grp_status[g] == gelt_pkg::GS_CREATED);
      creating = (grp_status[g] == gelt_pkg::GS_CREATING);
      case (r.action)
         gelt_pkg::ACT_CREATE_INIT: begin
            if (created) begin
               o.status = gelt_pkg::RSP_CREATED;
            end else if (creating && r.time_now < grp_expiry[g]) begin
               o.status       = gelt_pkg::RSP_CONFLICT;
               o.lease_expiry = grp_expiry[g];
            end else begin
               grp_status[g] = gelt_pkg::GS_CREATING;
               grp_txn[g]    = r.fresh_txn;
               grp_expiry[g] = lease_end(r.time_now, create_ticks);
               o.granted_txn = r.fresh_txn;
            end
         end
         gelt_pkg::ACT_CREATE_COMPLETE: begin
            if (created) begin
               o.status = gelt_pkg::RSP_CREATED;
            end else if (!creating || grp_txn[g] != r.txn_presented ||
                         grp_expiry[g] < r.time_now) begin
               o.status = gelt_pkg::RSP_BAD_TXN;
            end else begin
               grp_status[g]  = gelt_pkg::GS_CREATED;
               grp_epoch[g]   = '0;
               grp_pending[g] = 1'b0;
            end
         end
         gelt_pkg::ACT_COMMIT_INIT: begin
            if (!created) begin
               o.status = gelt_pkg::RSP_UNKNOWN;
            end else if (r.epoch_asked != grp_epoch[g]) begin
               o.status        = gelt_pkg::RSP_BAD_EPOCH;
               o.current_epoch = grp_epoch[g];
            end else if (grp_pending[g] && r.time_now < grp_expiry[g]) begin
               o.status       = gelt_pkg::RSP_CONFLICT;
               o.lease_expiry = grp_expiry[g];
            end else begin
               grp_pending[g] = 1'b1;
               grp_txn[g]     = r.fresh_txn;
               grp_expiry[g]  = lease_end(r.time_now, commit_ticks);
               o.granted_txn  = r.fresh_txn;
            end
         end
         default: begin
            if (!created) begin
               o.status = gelt_pkg::RSP_UNKNOWN;
            end else if (r.epoch_asked != grp_epoch[g]) begin
               o.status        = gelt_pkg::RSP_BAD_EPOCH;
               o.current_epoch = grp_epoch[g];
            end else if (!grp_pending[g] || grp_txn[g] != r.txn_presented ||
                         grp_expiry[g] < r.time_now) begin
               o.status = gelt_pkg::RSP_BAD_TXN;
            end else begin
               grp_epoch[g]   = grp_epoch[g] + 32'd1;
               grp_pending[g] = 1'b0;
            end
         end
      endcase
      return o;
   endfunction

   // Mostly well-formed traffic on a few hot groups, steered by the shadow table
   function automatic gelt_pkg::req_type random_request();
      gelt_pkg::req_type r;
      int unsigned       g;
      int unsigned       roll;
      roll = $urandom_range(0, 99);
      g    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, GROUPS - 1)
                                         : hot_base + $urandom_range(0, 5);
      tick_base += ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 40));
      r.group_index   = g[IDX_W-1:0];
      r.fresh_txn     = {$urandom, $urandom};
      r.time_now      = ($urandom_range(0, 19) == 0) ? $urandom : tick_base;
      r.epoch_asked   = ($urandom_range(0, 9) == 0) ? $urandom : grp_epoch[g];
      r.txn_presented = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : grp_txn[g];
      if (roll < 12) begin
         // noise: any action on whatever state the group is in
         r.action = 2'($urandom_range(0, 3));
      end else if (grp_status[g] == gelt_pkg::GS_CREATED) begin
         if (grp_pending[g])
            r.action = (roll < 65) ? gelt_pkg::ACT_COMMIT_COMPLETE
                                   : gelt_pkg::ACT_COMMIT_INIT;
         else
            r.action = (roll < 85) ? gelt_pkg::ACT_COMMIT_INIT
                                   : gelt_pkg::ACT_COMMIT_COMPLETE;
      end else if (grp_status[g] == gelt_pkg::GS_CREATING) begin
         r.action = (roll < 65) ? gelt_pkg::ACT_CREATE_COMPLETE
                                : gelt_pkg::ACT_CREATE_INIT;
      end else begin
         r.action = gelt_pkg::ACT_CREATE_INIT;
      end
      return r;
   endfunction

   task automatic add_row(logic [1:0] act, logic [IDX_W-1:0] g, logic [31:0] ep,
                          logic [63:0] txn, logic [63:0] fresh, logic [31:0] now,
                          bit typed, logic [2:0] st, logic [63:0] granted,
                          logic [31:0] lexp, logic [31:0] cep);
      dir_row_type row;
      row.req.action        = act;
      row.req.group_index   = g;
      row.req.epoch_asked   = ep;
      row.req.txn_presented = txn;
      row.req.fresh_txn     = fresh;
      row.req.time_now      = now;
      row.typed             = typed;
      row.rsp.status        = st;
      row.rsp.granted_txn   = granted;
      row.rsp.lease_expiry  = lexp;
      row.rsp.current_epoch = cep;
      dir_rows.push_back(row);
   endtask

   // Request beat: called at a falling edge, returns at the falling edge after acceptance
   task automatic send_req(gelt_pkg::req_type r, bit typed, gelt_pkg::rsp_type t);
      req_valid      <= 1'b1;
      req_payload    <= r;
      beat_typed     <= typed;
      beat_typed_rsp <= t;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic pause_req(int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Let every response drain, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Beat monitor: register writes, predictions and response checks
   always @(posedge clock) begin : monitor
      gelt_pkg::rsp_type want;
      gelt_pkg::rsp_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_beats++;
            if (csr_index == gelt_pkg::CSR_CREATE_LEASE)
               create_ticks = csr_data;
            else if (csr_index == gelt_pkg::CSR_COMMIT_LEASE)
               commit_ticks = csr_data;
         end
         if (req_valid && req_ready) begin
            req_beats++;
            want = lease_table_step(req_payload);
            if (beat_typed)
               want = beat_typed_rsp;
            awaited_rsp_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_beats++;
            got = rsp_payload;
            status_seen[got.status]++;
            if (awaited_rsp_q.size() == 0) begin
               fault_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("[%0t] response with nothing awaited: status %0d", $realtime,
                           got.status);
               end
            end else begin
               want = awaited_rsp_q.pop_front();
               if (got.status !== want.status || got.granted_txn !== want.granted_txn ||
                   got.lease_expiry !== want.lease_expiry ||
                   got.current_epoch !== want.current_epoch) begin
                  fault_count++;
                  if (report_count < MAX_REPORTS) begin
                     report_count++;
                     $display("[%0t] response %0d mismatch:", $realtime, rsp_beats);
                     $display("   status  exp %0d got %0d", want.status, got.status);
                     $display("   granted exp %h got %h", want.granted_txn, got.granted_txn);
                     $display("   expiry  exp %h got %h", want.lease_expiry,
                              got.lease_expiry);
                     $display("   epoch   exp %h got %h", want.current_epoch,
                              got.current_epoch);
                  end
               end
            end
         end
      end
   end

   // Response side: random ready bursts, one long hold-off on request, none when calm
   initial begin : rsp_side
      int unsigned run_left;
      run_left  = 0;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_ready <= 1'b1;
            run_left = 0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else if (run_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
               rsp_ready <= 1'b0;
               run_left = $urandom_range(1, 9);
            end else begin
               rsp_ready <= 1'b1;
               run_left = $urandom_range(1, 30);
            end
         end
         if (run_left != 0)
            run_left--;
      end
   end

   // Cycle limit
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Cycle limit reached with %0d responses still awaited.", awaited_rsp_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      gelt_pkg::req_type r;
      int unsigned       p;
      int unsigned       i;
      int unsigned       dir_count;
      logic [31:0]       phase_create [PHASES];
      logic [31:0]       phase_commit [PHASES];

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      beat_typed     = 1'b0;
      beat_typed_rsp = '0;
      calm           = 1'b0;
      hold_rsp       = 1'b0;
      tick_base      = '0;
      hot_base       = 0;
      fault_count    = 0;
      report_count   = 0;
      req_beats      = 0;
      rsp_beats      = 0;
      csr_beats      = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
      for (int k = 0; k < GROUPS; k++) begin
         grp_status[k]  = gelt_pkg::GS_EMPTY;
         grp_pending[k] = 1'b0;
         grp_txn[k]     = '0;
         grp_expiry[k]  = '0;
         grp_epoch[k]   = '0;
      end
      create_ticks = gelt_pkg::LEASE_TICKS_RESET;
      commit_ticks = gelt_pkg::LEASE_TICKS_RESET;

      // lease lengths per random phase: zero, maximum, short, near-wrap time, mixed, calm
      phase_create[0] = 32'd0;                  phase_commit[0] = 32'd0;
      phase_create[1] = T_MAX;                  phase_commit[1] = T_MAX;
      phase_create[2] = 32'd40;                 phase_commit[2] = 32'd90;
      phase_create[3] = $urandom_range(0, 300); phase_commit[3] = $urandom_range(0, 300);
      phase_create[4] = T_MAX;                  phase_commit[4] = 32'd0;
      phase_create[5] = $urandom_range(20, 200); phase_commit[5] = $urandom_range(20, 200);

      // Directed rows, leases of 1000 ticks
      // create lease, clash with it, wrong id, complete on the expiry tick
      add_row(CR_INIT, 0, 0, 0, TXN_A, 100, 1, S_OK, TXN_A, 0, 0);
      add_row(CR_INIT, 0, 0, 0, TXN_B, 200, 1, S_CONFLICT, 0, 1100, 0);
      add_row(CR_DONE, 0, 0, TXN_B, 0, 300, 1, S_BAD_TXN, 0, 0, 0);
      add_row(CR_DONE, 0, 0, TXN_A, 0, 1100, 1, S_OK, 0, 0, 0);
      // created group refuses create actions
      add_row(CR_INIT, 0, 0, 0, TXN_B, 1200, 1, S_CREATED, 0, 0, 0);
      add_row(CR_DONE, 0, 0, TXN_A, 0, 1200, 1, S_CREATED, 0, 0, 0);
      // wrong epoch, group never created, complete on an empty group, nothing pending
      add_row(CM_INIT, 0, 5, 0, TXN_B, 1300, 1, S_BAD_EPOCH, 0, 0, 0);
      add_row(CM_INIT, 1, 0, 0, TXN_B, 1300, 1, S_UNKNOWN, 0, 0, 0);
      add_row(CM_DONE, 1, 0, TXN_B, 0, 1300, 1, S_UNKNOWN, 0, 0, 0);
      add_row(CR_DONE, 3, 0, 0, 0, 1300, 1, S_BAD_TXN, 0, 0, 0);
      add_row(CM_DONE, 0, 0, TXN_B, 0, 1300, 1, S_BAD_TXN, 0, 0, 0);
      // commit lease saturates at the top of time, takeover on the expiry tick
      add_row(CM_INIT, 0, 0, 0, TXN_B, 32'hFFFF_FF00, 1, S_OK, TXN_B, 0, 0);
      add_row(CM_INIT, 0, 0, 0, TXN_C, 32'hFFFF_FFFE, 1, S_CONFLICT, 0, T_MAX, 0);
      add_row(CM_INIT, 0, 0, 0, TXN_C, T_MAX, 1, S_OK, TXN_C, 0, 0);
      add_row(CM_DONE, 0, 0, TXN_B, 0, T_MAX, 1, S_BAD_TXN, 0, 0, 0);
      add_row(CM_DONE, 0, 0, TXN_C, 0, T_MAX, 1, S_OK, 0, 0, 0);
      add_row(CM_DONE, 0, 0, TXN_C, 0, 0, 1, S_BAD_EPOCH, 0, 0, 1);
      // all-ones fields on the top group
      add_row(CR_INIT, 255, T_MAX, TXN_ONES, TXN_ONES, T_MAX, 1, S_OK, TXN_ONES, 0, 0);
      add_row(CR_DONE, 255, T_MAX, TXN_ONES, 0, 0, 1, S_OK, 0, 0, 0);
      // expired create lease: complete refused, init on the expiry tick takes over
      add_row(CR_INIT, 2, 0, 0, 0, 5000, 1, S_OK, 0, 0, 0);
      add_row(CR_DONE, 2, 0, 0, 0, 6001, 1, S_BAD_TXN, 0, 0, 0);
      add_row(CR_INIT, 2, 0, 0, TXN_A, 6000, 1, S_OK, TXN_A, 0, 0);
      // left to the predictor
      add_row(CM_INIT, 0, 1, 0, TXN_A, 500, 0, S_OK, 0, 0, 0);
      add_row(CM_DONE, 0, 1, TXN_A, 0, 1500, 0, S_OK, 0, 0, 0);
      add_row(CM_INIT, 255, 0, 0, TXN_B, 700, 0, S_OK, 0, 0, 0);
      dir_count = dir_rows.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers at their reset values, plus a write to an unused index
      write_csr(gelt_pkg::CSR_CREATE_LEASE, gelt_pkg::LEASE_TICKS_RESET);
      write_csr(gelt_pkg::CSR_COMMIT_LEASE, gelt_pkg::LEASE_TICKS_RESET);
      write_csr({CSR_W{1'b1}}, T_MAX);

      foreach (dir_rows[k])
         send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);

      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         write_csr(gelt_pkg::CSR_CREATE_LEASE, phase_create[p]);
         write_csr(gelt_pkg::CSR_COMMIT_LEASE, phase_commit[p]);
         if ($urandom_range(0, 1) == 0)
            write_csr(CSR_W'($urandom_range(2, 255)), $urandom);
         // fresh hot groups each phase so create traffic keeps going
         hot_base  = (p == 4) ? 250 : 8 + p * 40;
         tick_base = (p == 3) ? 32'hFFFF_F000 : 32'($urandom_range(0, 1 << 20));
         calm      = (p == PHASES - 1);
         if (p == 2)
            hold_rsp = 1'b1;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (!calm && $urandom_range(0, 3) == 0)
               pause_req($urandom_range(1, 9));
            r = random_request();
            send_req(r, 1'b0, '0);
         end
      end

      wait_idle();
      $display("Ran %0d requests (%0d directed) under %0d lease settings, %0d csr writes.",
               req_beats, dir_count, PHASES + 1, csr_beats);
      $display("Statuses: ok %0d created %0d conflict %0d bad-txn %0d unknown %0d bad-epoch %0d",
               status_seen[gelt_pkg::RSP_OK], status_seen[gelt_pkg::RSP_CREATED],
               status_seen[gelt_pkg::RSP_CONFLICT], status_seen[gelt_pkg::RSP_BAD_TXN],
               status_seen[gelt_pkg::RSP_UNKNOWN], status_seen[gelt_pkg::RSP_BAD_EPOCH]);
      if (fault_count == 0 && awaited_rsp_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d faults, %0d responses never seen.", fault_count, awaited_rsp_q.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
